@@ hw/rtl/htfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TEMP_CRC = 2'd1,
		ST_RH_CRC   = 2'd2,
		ST_BUS_FAIL = 2'd3
	} status_t;

	// one finished frame or bus failure, handed from the front to the back
	typedef struct packed {
		status_t     status;
		logic [15:0] temp_raw;
		logic [15:0] rh_raw;
	} cmd_t;

	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] RH_SCALE    = 14'd12500;
	localparam logic [13:0] RH_OFFSET   = 14'd600;
	localparam logic [13:0] RH_MAX      = 14'd10000;
	localparam logic [31:0] ROUND_BIAS  = 32'd32767;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/htfd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module htfd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            kind,
	input  wire logic [7:0]      byte_value,
	input  wire logic            frame_start,
	output logic                 push,
	output htfd_pkg::cmd_t       push_cmd
);

	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic        temp_ok_q;
	logic [15:0] temp_raw_q;
	logic [15:0] rh_raw_q;

	logic        restart;
	logic [2:0]  pos_eff;
	logic [7:0]  crc_eff;
	logic [7:0]  crc_next;

	always_comb begin
		restart  = frame_start || (pos_q > POS_H_CRC);
		pos_eff  = restart ? POS_T_HI : pos_q;
		crc_eff  = restart ? htfd_pkg::CRC_INIT : crc_q;
		crc_next = htfd_pkg::crc8_step(crc_eff, byte_value);
	end

	assign push = accept && (kind || (pos_eff == POS_H_CRC));

	always_comb begin
		push_cmd.temp_raw = temp_raw_q;
		push_cmd.rh_raw   = rh_raw_q;
		if (kind) begin
			push_cmd.status = htfd_pkg::ST_BUS_FAIL;
		end else if (!temp_ok_q) begin
			push_cmd.status = htfd_pkg::ST_TEMP_CRC;
		end else if (crc_eff != byte_value) begin
			push_cmd.status = htfd_pkg::ST_RH_CRC;
		end else begin
			push_cmd.status = htfd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_T_HI;
			crc_q     <= htfd_pkg::CRC_INIT;
			temp_ok_q <= 1'b0;
		end else if (accept) begin
			if (kind) begin
				pos_q <= POS_T_HI;
				crc_q <= htfd_pkg::CRC_INIT;
			end else begin
				pos_q <= (pos_eff == POS_H_CRC) ? POS_T_HI : pos_eff + 3'd1;
				case (pos_eff)
					POS_T_HI, POS_T_LO, POS_H_HI, POS_H_LO: begin
						crc_q <= crc_next;
					end
					POS_T_CRC: begin
						temp_ok_q <= (crc_eff == byte_value);
						crc_q     <= htfd_pkg::CRC_INIT;
					end
					default: begin
						crc_q <= htfd_pkg::CRC_INIT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !kind) begin
			case (pos_eff)
				POS_T_HI: begin
					temp_raw_q <= {byte_value, 8'h00};
				end
				POS_T_LO: begin
					temp_raw_q[7:0] <= byte_value;
				end
				POS_H_HI: begin
					rh_raw_q <= {byte_value, 8'h00};
				end
				POS_H_LO: begin
					rh_raw_q[7:0] <= byte_value;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/htfd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module htfd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire htfd_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output htfd_pkg::cmd_t       pop_cmd,
	output logic                 not_empty
);

	localparam int Depth = htfd_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	htfd_pkg::cmd_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/htfd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module htfd_back #(
	parameter int COUNTER_WIDTH = htfd_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	input  wire htfd_pkg::cmd_t     cmd,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [1:0]              status,
	output logic signed [14:0]      temp_centi,
	output logic [13:0]             rh_centi,
	output logic                    valid_res,
	output logic [31:0]             sample_total,
	output logic [31:0]             error_total
);

	// round(n / 65535) for n below 2^31: bias by half, then the exact
	// divide-by-65535 identity q = (m + (m >> 16) + 1) >> 16
	function automatic logic [15:0] div65535_round(input logic [31:0] n);
		logic [31:0] m;
		logic [31:0] s;
		m = n + htfd_pkg::ROUND_BIAS;
		s = m + {16'h0000, m[31:16]} + 32'd1;
		return s[31:16];
	endfunction

	logic advance;

	logic            v_s1;
	htfd_pkg::status_t st_s1;
	logic [30:0]     tmul_s1;
	logic [29:0]     hmul_s1;

	logic            v_s2;
	htfd_pkg::status_t st_s2;
	logic [14:0]     tq_s2;
	logic [13:0]     hq_s2;

	logic [15:0]     tq_full;
	logic [15:0]     hq_full;
	logic [14:0]     temp_new;
	logic [13:0]     rh_new;
	logic [13:0]     rh_sub;

	logic                     out_valid_q;
	htfd_pkg::status_t        status_q;
	logic [14:0]              latest_temp_q;
	logic [13:0]              latest_rh_q;
	logic                     ever_valid_q;
	logic [COUNTER_WIDTH-1:0] samples_q;
	logic [COUNTER_WIDTH-1:0] errors_q;

	assign advance = !out_valid_q || res_ready;
	assign pop     = advance && cmd_valid;

	assign tq_full = div65535_round({1'b0, tmul_s1});
	assign hq_full = div65535_round({2'b00, hmul_s1});

	always_comb begin
		temp_new = tq_s2 - htfd_pkg::TEMP_OFFSET;
		rh_sub   = hq_s2 - htfd_pkg::RH_OFFSET;
		if (hq_s2 < htfd_pkg::RH_OFFSET) begin
			rh_new = '0;
		end else if (rh_sub > htfd_pkg::RH_MAX) begin
			rh_new = htfd_pkg::RH_MAX;
		end else begin
			rh_new = rh_sub;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (advance) begin
			st_s1   <= cmd.status;
			tmul_s1 <= 31'(cmd.temp_raw * htfd_pkg::TEMP_SCALE);
			hmul_s1 <= 30'(cmd.rh_raw * htfd_pkg::RH_SCALE);
			st_s2   <= st_s1;
			tq_s2   <= tq_full[14:0];
			hq_s2   <= hq_full[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= htfd_pkg::ST_OK;
			latest_temp_q <= '0;
			latest_rh_q   <= '0;
			ever_valid_q  <= 1'b0;
			samples_q     <= '0;
			errors_q      <= '0;
		end else if (advance) begin
			v_s1        <= cmd_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
			if (v_s2) begin
				status_q  <= st_s2;
				samples_q <= samples_q + 1'b1;
				if (st_s2 == htfd_pkg::ST_OK) begin
					latest_temp_q <= temp_new;
					latest_rh_q   <= rh_new;
					ever_valid_q  <= 1'b1;
				end else begin
					errors_q <= errors_q + 1'b1;
				end
			end
		end
	end

	assign res_valid    = out_valid_q;
	assign status       = status_q;
	assign temp_centi   = latest_temp_q;
	assign rh_centi     = latest_rh_q;
	assign valid_res    = ever_valid_q;
	assign sample_total = 32'(samples_q);
	assign error_total  = 32'(errors_q);

endmodule

`default_nettype wire

@@ hw/rtl/humidity_temp_frame_decoder.sv @@
// path: the sixth byte of a reply, or a bus-failure item, passes the queue, the product stage and
// the divide stage, then the result register; a stalled result holds all of them
// throughput: one item per cycle while the queue is not full; a four-entry queue takes items while a result waits
// reset: arst_n clears frame position, crc, queue, counters and stored readings at once
`timescale 1ns / 1ps
`default_nettype none

module humidity_temp_frame_decoder #(
	parameter int COUNTER_WIDTH = htfd_pkg::COUNTER_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         byte_value,
	input  wire logic               frame_start,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [1:0]              status,
	output logic signed [14:0]      temp_centi,
	output logic [13:0]             rh_centi,
	output logic                    valid_res,
	output logic [31:0]             sample_total,
	output logic [31:0]             error_total
);

	logic           accept;
	logic           push;
	logic           full;
	logic           pop;
	logic           not_empty;
	htfd_pkg::cmd_t push_cmd;
	htfd_pkg::cmd_t pop_cmd;

	assign byte_ready = !full;
	assign accept     = byte_valid && byte_ready;

	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.byte_value  (byte_value),
		.frame_start (frame_start),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	htfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	htfd_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (not_empty),
		.cmd          (pop_cmd),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.temp_centi   (temp_centi),
		.rh_centi     (rh_centi),
		.valid_res    (valid_res),
		.sample_total (sample_total),
		.error_total  (error_total)
	);

endmodule

`default_nettype wire

@@ hw/rtl/htfd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module htfd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [1:0]        status,
	input wire logic [13:0]       rh_centi,
	input wire logic              valid_res
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(rh_centi))
	else $error("result changed while stalled");

	// an ok result always carries a good reading
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == htfd_pkg::ST_OK) |-> valid_res)
	else $error("ok status without valid reading");

	// once a good reading is stored it never goes away
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(valid_res) |-> valid_res)
	else $error("valid flag dropped");

	// humidity stays clamped
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> rh_centi <= htfd_pkg::RH_MAX)
	else $error("humidity out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.status    (status),
	.rh_centi  (rh_centi),
	.valid_res (valid_res)
);

`default_nettype wire

@@ bench/humidity_temp_frame_checker.sv @@
`timescale 1ns / 1ps

module humidity_temp_frame_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	input  wire logic               byte_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         byte_value,
	input  wire logic               frame_start,
	input  wire logic               res_valid,
	input  wire logic               res_ready,
	input  wire logic [1:0]         status,
	input  wire logic signed [14:0] temp_centi,
	input  wire logic [13:0]        rh_centi,
	input  wire logic               valid_res,
	input  wire logic [31:0]        sample_total,
	input  wire logic [31:0]        error_total,
	output int unsigned             outstanding,
	output int unsigned             fail_count
);

	typedef struct packed {
		htfd_pkg::status_t  status;
		logic signed [14:0] temp;
		logic [13:0]        rh;
		logic               good_seen;
		logic [31:0]        samples;
		logic [31:0]        errors;
	} reading_t;

	logic [2:0]         frame_pos;
	logic [7:0]         frame_crc;
	logic [15:0]        temp_word;
	logic [15:0]        rh_word;
	logic               temp_crc_ok;
	logic signed [14:0] good_temp;
	logic [13:0]        good_rh;
	logic               good_seen;
	logic [31:0]        samples;
	logic [31:0]        errors;
	int unsigned        mismatches;
	int unsigned        results_seen;
	reading_t           readings_due[$];

	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		repeat (8) c = c[7] ? ((c << 1) ^ htfd_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	// round to nearest: the quotient by 65535 never lands on a half
	function automatic logic signed [14:0] temp_hundredths(input logic [15:0] raw);
		longint q;
		q = (longint'(raw) * 35000 + 65535) / 131070;
		return 15'(q - 4500);
	endfunction

	function automatic logic [13:0] rh_hundredths(input logic [15:0] raw);
		longint q;
		q = (longint'(raw) * 25000 + 65535) / 131070 - 600;
		if (q < 0)
			q = 0;
		if (q > 10000)
			q = 10000;
		return 14'(q);
	endfunction

	task automatic post_reading(input htfd_pkg::status_t st);
		reading_t r;
		r.status    = st;
		r.temp      = good_temp;
		r.rh        = good_rh;
		r.good_seen = good_seen;
		r.samples   = samples;
		r.errors    = errors;
		readings_due.push_back(r);
	endtask

	task automatic take_item(input logic k, input logic [7:0] b, input logic st);
		logic rh_crc_ok;
		if (k) begin
			// bus failure drops whatever part of the frame was collected
			frame_pos = 3'd0;
			frame_crc = htfd_pkg::CRC_INIT;
			samples++;
			errors++;
			post_reading(htfd_pkg::ST_BUS_FAIL);
		end else begin
			if (st || frame_pos > 3'd5) begin
				frame_pos = 3'd0;
				frame_crc = htfd_pkg::CRC_INIT;
			end
			case (frame_pos)
				3'd0: begin
					temp_word = {b, 8'h00};
					frame_crc = crc_fold(frame_crc, b);
				end
				3'd1: begin
					temp_word[7:0] = b;
					frame_crc = crc_fold(frame_crc, b);
				end
				3'd2: begin
					temp_crc_ok = (frame_crc == b);
					frame_crc = htfd_pkg::CRC_INIT;
				end
				3'd3: begin
					rh_word = {b, 8'h00};
					frame_crc = crc_fold(frame_crc, b);
				end
				3'd4: begin
					rh_word[7:0] = b;
					frame_crc = crc_fold(frame_crc, b);
				end
				default: ;
			endcase
			if (frame_pos < 3'd5) begin
				frame_pos++;
			end else begin
				rh_crc_ok = (frame_crc == b);
				frame_pos = 3'd0;
				frame_crc = htfd_pkg::CRC_INIT;
				samples++;
				if (!temp_crc_ok) begin
					errors++;
					post_reading(htfd_pkg::ST_TEMP_CRC);
				end else if (!rh_crc_ok) begin
					errors++;
					post_reading(htfd_pkg::ST_RH_CRC);
				end else begin
					good_temp = temp_hundredths(temp_word);
					good_rh   = rh_hundredths(rh_word);
					good_seen = 1'b1;
					post_reading(htfd_pkg::ST_OK);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		if (!arst_n) begin
			frame_pos    = 3'd0;
			frame_crc    = htfd_pkg::CRC_INIT;
			temp_word    = 16'd0;
			rh_word      = 16'd0;
			temp_crc_ok  = 1'b0;
			good_temp    = 15'sd0;
			good_rh      = 14'd0;
			good_seen    = 1'b0;
			samples      = 32'd0;
			errors       = 32'd0;
			mismatches   = 0;
			results_seen = 0;
			readings_due.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// results leave only after their item has passed the queue and the pipeline registers, so check first
			if (res_valid && res_ready) begin
				results_seen++;
				if (readings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d with none due: st %0d t %0d rh %0d v %0d n %0d e %0d",
							results_seen, status, temp_centi, rh_centi, valid_res,
							sample_total, error_total);
				end else begin
					want = readings_due.pop_front();
					if (status !== want.status || temp_centi !== want.temp
							|| rh_centi !== want.rh || valid_res !== want.good_seen
							|| sample_total !== want.samples || error_total !== want.errors) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d expected: st %0d t %0d rh %0d v %0d n %0d e %0d",
								results_seen, want.status, want.temp, want.rh, want.good_seen,
								want.samples, want.errors);
							$display("result %0d got:      st %0d t %0d rh %0d v %0d n %0d e %0d",
								results_seen, status, temp_centi, rh_centi, valid_res,
								sample_total, error_total);
						end
					end
				end
			end
			if (byte_valid && byte_ready)
				take_item(kind, byte_value, frame_start);
			outstanding <= readings_due.size();
			fail_count  <= mismatches;
		end
	end

endmodule

@@ bench/humidity_temp_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;

	localparam int   ITEMS     = 1400;
	localparam int   LIMIT     = 1000000;
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_FAIL = 1'b1;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic byte_valid  = 1'b0;
	logic kind        = 1'b0;
	logic [7:0] byte_value = 8'd0;
	logic frame_start = 1'b0;
	logic res_ready   = 1'b0;

	logic               byte_ready;
	logic               res_valid;
	logic [1:0]         status;
	logic signed [14:0] temp_centi;
	logic [13:0]        rh_centi;
	logic               valid_res;
	logic [31:0]        sample_total;
	logic [31:0]        error_total;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned items_sent = 0;
	int unsigned cycles     = 0;
	int unsigned stall_left = 0;
	logic        no_gaps    = 1'b0;

	humidity_temp_frame_decoder dut (
		.clk, .arst_n, .byte_valid, .byte_ready, .kind, .byte_value, .frame_start,
		.res_valid, .res_ready, .status, .temp_centi, .rh_centi, .valid_res,
		.sample_total, .error_total
	);

	humidity_temp_frame_checker chk (
		.clk, .arst_n, .byte_valid, .byte_ready, .kind, .byte_value, .frame_start,
		.res_valid, .res_ready, .status, .temp_centi, .rh_centi, .valid_res,
		.sample_total, .error_total, .outstanding, .fail_count
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("humidity_temp_frame_decoder: mismatch");
			$finish;
		end
	end

	// result side: random stalls, with a stretch of steady ready every so often
	always @(posedge clk) begin : rx_pace
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (cycles[10:8] == 3'd5) begin
			res_ready <= 1'b1;
		end else if (stall_left != 0) begin
			res_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (pick < 70) begin
			res_ready <= 1'b1;
		end else if (pick < 95) begin
			res_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			res_ready  <= 1'b0;
			stall_left <= $urandom_range(10, 80);
		end
	end

	function automatic logic [7:0] pair_crc(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] c;
		c = 8'hFF ^ hi;
		repeat (8) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
		c = c ^ lo;
		repeat (8) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
		return c;
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(3140, 3152));    // humidity crosses zero
			3: return 16'($urandom_range(55568, 55580));  // humidity crosses 100 %
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 65)
			return 0;
		if (pick < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input logic k, input logic [7:0] b, input logic st);
		int unsigned gap;
		logic        took;
		gap = pick_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid  <= 1'b1;
		kind        <= k;
		byte_value  <= b;
		frame_start <= st;
		do begin
			@(negedge clk);
			took = byte_ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic st,
			input logic spoil_t, input logic spoil_h);
		logic [7:0] tc;
		logic [7:0] hc;
		tc = pair_crc(t[15:8], t[7:0]) ^ (spoil_t ? 8'($urandom_range(1, 255)) : 8'h00);
		hc = pair_crc(h[15:8], h[7:0]) ^ (spoil_h ? 8'($urandom_range(1, 255)) : 8'h00);
		send_item(KIND_BYTE, t[15:8], st);
		send_item(KIND_BYTE, t[7:0], 1'b0);
		send_item(KIND_BYTE, tc, 1'b0);
		send_item(KIND_BYTE, h[15:8], 1'b0);
		send_item(KIND_BYTE, h[7:0], 1'b0);
		send_item(KIND_BYTE, hc, 1'b0);
	endtask

	initial begin : stimulus
		int unsigned pick;
		int unsigned n;
		logic        drained;
		drained = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowest readings, humidity clamped at zero
		send_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
		// highest readings, first byte taken without a frame start
		send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		// failure in the middle of a frame
		send_item(KIND_BYTE, 8'h66, 1'b1);
		send_item(KIND_BYTE, 8'h66, 1'b0);
		send_item(KIND_FAIL, 8'h00, 1'b0);
		// failure with no frame open, ignored fields set
		send_item(KIND_FAIL, 8'hFF, 1'b1);
		// abandoned frame, then a restart with both checks bad
		send_item(KIND_BYTE, 8'hA5, 1'b1);
		send_item(KIND_BYTE, 8'h5A, 1'b0);
		send_frame(16'h1234, 16'h0C4A, 1'b1, 1'b1, 1'b1);

		while (items_sent < ITEMS) begin
			no_gaps = ($urandom_range(0, 7) == 0);
			if (!drained && items_sent >= ITEMS / 2) begin
				// hold the sender until the block has nothing left to deliver
				drained = 1'b1;
				byte_valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(pick_raw(), pick_raw(), $urandom_range(0, 9) != 0,
					$urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
			end else if (pick < 85) begin
				n = $urandom_range(1, 5);
				send_item(KIND_BYTE, 8'($urandom), 1'b1);
				repeat (n - 1) send_item(KIND_BYTE, 8'($urandom), 1'b0);
			end else if (pick < 93) begin
				send_item(KIND_FAIL, 8'($urandom), 1'($urandom));
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) send_item($urandom_range(0, 9) == 0 ? KIND_FAIL : KIND_BYTE,
					8'($urandom), $urandom_range(0, 3) == 0);
			end
		end

		byte_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("humidity_temp_frame_decoder: match");
		else
			$display("humidity_temp_frame_decoder: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_front.sv
hw/rtl/htfd_queue.sv
hw/rtl/htfd_back.sv
hw/rtl/humidity_temp_frame_decoder.sv
hw/rtl/htfd_checker.sv
bench/humidity_temp_frame_checker.sv
bench/humidity_temp_frame_decoder_tb.sv
